// ===== rtl/mitp_pkg.sv =====
// shared types, codes and constants of the madt interrupt table parser
`timescale 1ns / 1ps

package mitp_pkg;

    // parameter defaults
    localparam int LEGACY_IRQS_DEF      = 16;
    localparam int ENTRY_BYTES_KEPT_DEF = 12;

    // stream widths
    localparam int S_TDATA_W = 16;
    localparam int S_TUSER_W = 3;
    localparam int M_DATA_W  = 149;
    localparam int M_TDATA_W = 152;

    // request codes carried in tuser
    typedef enum logic [1:0] {
        FUNC_CLEAR  = 2'd0,
        FUNC_BYTE   = 2'd1,
        FUNC_LOOKUP = 2'd2,
        FUNC_NONE   = 2'd3
    } func_t;

    // entry type codes
    localparam logic [7:0] KIND_LAPIC     = 8'd0;
    localparam logic [7:0] KIND_IOAPIC    = 8'd1;
    localparam logic [7:0] KIND_OVERRIDE  = 8'd2;
    localparam logic [7:0] KIND_LAPIC_ADR = 8'd5;

    // header layout
    localparam logic [31:0] OFS_LEN_LO   = 32'd4;
    localparam logic [31:0] OFS_HDR_MIN  = 32'd8;
    localparam logic [31:0] OFS_LAPIC_LO = 32'd36;
    localparam logic [31:0] OFS_LAPIC_HI = 32'd40;
    localparam logic [31:0] OFS_ENTRIES  = 32'd44;

    localparam logic [7:0]  ENTRY_LEN_MIN  = 8'd2;
    localparam logic [31:0] LAPIC_DEFAULT  = 32'hFEE0_0000;
    localparam logic [1:0]  FLAG_ASSERTED  = 2'b11;

    // status fields from the parser
    typedef struct packed {
        logic [7:0]  boot_id;
        logic        boot_found;
        logic [31:0] lapic_base;
        logic [7:0]  io_apic_id;
        logic [31:0] ioapic_base;
        logic [31:0] ioapic_gsi;
        logic        done;
        logic        error;
    } status_t;

    // legacy irq table write request
    typedef struct packed {
        logic        en;
        logic [7:0]  src;
        logic [31:0] gsi;
        logic        low;
        logic        level;
    } irq_wr_t;

    // legacy irq lookup result
    typedef struct packed {
        logic [31:0] gsi;
        logic        low;
        logic        level;
    } irq_look_t;

endpackage

// ===== rtl/mitp_parser.sv =====
// byte walker of the madt header and entry chain with the result registers
`timescale 1ns / 1ps

module mitp_parser #(
    parameter int LEGACY_IRQS      = mitp_pkg::LEGACY_IRQS_DEF,
    parameter int ENTRY_BYTES_KEPT = mitp_pkg::ENTRY_BYTES_KEPT_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  mitp_pkg::func_t     func,
    input  logic                table_start,
    input  logic [7:0]          data_byte,
    output mitp_pkg::status_t   status,
    output mitp_pkg::irq_wr_t   irq_wr
);

    logic [31:0] offset_reg, offset_next;
    logic [31:0] tlen_reg, tlen_next;
    logic [7:0]  pos_reg, pos_next;
    logic [7:0]  elen_reg, elen_next;
    logic [7:0]  kind_reg, kind_next;
    logic [7:0]  boot_id_reg, boot_id_next;
    logic        boot_found_reg, boot_found_next;
    logic [31:0] lapic_reg, lapic_next;
    logic [7:0]  io_apic_id_reg, io_apic_id_next;
    logic [31:0] ioapic_base_reg, ioapic_base_next;
    logic [31:0] ioapic_gsi_reg, ioapic_gsi_next;
    logic        error_reg, error_next;
    logic [7:0]  body_reg [ENTRY_BYTES_KEPT];
    logic [7:0]  body_next [ENTRY_BYTES_KEPT];
    logic [7:0]  bv [ENTRY_BYTES_KEPT];

    logic [31:0] o_eff;
    logic [31:0] tl_eff;
    logic [7:0]  pos_eff;
    logic        err_eff;
    logic        take;
    logic        apply;
    logic [7:0]  pm2;
    logic [31:0] bv32_2;
    logic [31:0] bv32_6;

    // view of the start of a new table
    always_comb
    begin
        o_eff   = table_start ? '0 : offset_reg;
        tl_eff  = table_start ? '0 : tlen_reg;
        pos_eff = table_start ? '0 : pos_reg;
        err_eff = table_start ? 1'b0 : error_reg;
        take    = !err_eff && !(o_eff >= mitp_pkg::OFS_HDR_MIN && o_eff >= tl_eff);
        pm2     = pos_eff - 8'd2;
    end

    // entry body as it stands with the current byte merged in
    always_comb
    begin
        for (int i = 0; i < ENTRY_BYTES_KEPT; i++)
        begin
            if (pos_eff == 8'd1)
                bv[i] = '0;
            else if (pos_eff >= 8'd2 && pm2 == 8'(i))
                bv[i] = data_byte;
            else
                bv[i] = body_reg[i];
        end
        bv32_2 = {bv[5], bv[4], bv[3], bv[2]};
        bv32_6 = {bv[9], bv[8], bv[7], bv[6]};
    end

    // byte walk and entry decode
    always_comb
    begin
        offset_next      = offset_reg;
        tlen_next        = tlen_reg;
        pos_next         = pos_reg;
        elen_next        = elen_reg;
        kind_next        = kind_reg;
        boot_id_next     = boot_id_reg;
        boot_found_next  = boot_found_reg;
        lapic_next       = lapic_reg;
        io_apic_id_next  = io_apic_id_reg;
        ioapic_base_next = ioapic_base_reg;
        ioapic_gsi_next  = ioapic_gsi_reg;
        error_next       = error_reg;
        body_next        = body_reg;
        apply            = 1'b0;
        irq_wr           = '0;

        if (step)
        begin
            unique case (func)
                mitp_pkg::FUNC_CLEAR:
                begin
                    offset_next      = '0;
                    tlen_next        = '0;
                    pos_next         = '0;
                    elen_next        = '0;
                    kind_next        = '0;
                    boot_id_next     = '0;
                    boot_found_next  = 1'b0;
                    lapic_next       = mitp_pkg::LAPIC_DEFAULT;
                    io_apic_id_next  = '0;
                    ioapic_base_next = '0;
                    ioapic_gsi_next  = '0;
                    error_next       = 1'b0;
                end
                mitp_pkg::FUNC_BYTE:
                begin
                    offset_next = o_eff;
                    tlen_next   = tl_eff;
                    pos_next    = pos_eff;
                    error_next  = err_eff;
                    if (take)
                    begin
                        offset_next = o_eff + 32'd1;
                        if (o_eff >= mitp_pkg::OFS_LEN_LO && o_eff < mitp_pkg::OFS_HDR_MIN)
                        begin
                            case (o_eff[1:0])
                                2'd0:    tlen_next[7:0]   = data_byte;
                                2'd1:    tlen_next[15:8]  = data_byte;
                                2'd2:    tlen_next[23:16] = data_byte;
                                default: tlen_next[31:24] = data_byte;
                            endcase
                        end
                        else if (o_eff >= mitp_pkg::OFS_LAPIC_LO &&
                                 o_eff < mitp_pkg::OFS_LAPIC_HI)
                        begin
                            case (o_eff[1:0])
                                2'd0:    lapic_next[7:0]   = data_byte;
                                2'd1:    lapic_next[15:8]  = data_byte;
                                2'd2:    lapic_next[23:16] = data_byte;
                                default: lapic_next[31:24] = data_byte;
                            endcase
                        end
                        else if (o_eff >= mitp_pkg::OFS_ENTRIES)
                        begin
                            if (pos_eff == 8'd0)
                            begin
                                kind_next = data_byte;
                                pos_next  = 8'd1;
                            end
                            else if (pos_eff == 8'd1)
                            begin
                                elen_next = data_byte;
                                for (int i = 0; i < ENTRY_BYTES_KEPT; i++)
                                    body_next[i] = '0;
                                if (data_byte < mitp_pkg::ENTRY_LEN_MIN)
                                begin
                                    error_next = 1'b1;
                                    pos_next   = 8'd0;
                                end
                                else if (data_byte == mitp_pkg::ENTRY_LEN_MIN)
                                begin
                                    apply    = 1'b1;
                                    pos_next = 8'd0;
                                end
                                else
                                begin
                                    pos_next = 8'd2;
                                end
                            end
                            else
                            begin
                                for (int i = 0; i < ENTRY_BYTES_KEPT; i++)
                                begin
                                    if (pm2 == 8'(i))
                                        body_next[i] = data_byte;
                                end
                                if ({1'b0, pos_eff} + 9'd1 >= {1'b0, elen_reg})
                                begin
                                    apply    = 1'b1;
                                    pos_next = 8'd0;
                                end
                                else
                                begin
                                    pos_next = pos_eff + 8'd1;
                                end
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end

        // a completed entry takes effect
        if (apply)
        begin
            case (kind_reg)
                mitp_pkg::KIND_LAPIC:
                begin
                    if (!boot_found_reg && bv[2][0])
                    begin
                        boot_id_next    = bv[1];
                        boot_found_next = 1'b1;
                    end
                end
                mitp_pkg::KIND_IOAPIC:
                begin
                    io_apic_id_next  = bv[0];
                    ioapic_base_next = bv32_2;
                    ioapic_gsi_next  = bv32_6;
                end
                mitp_pkg::KIND_OVERRIDE:
                begin
                    if (32'(bv[1]) < LEGACY_IRQS)
                    begin
                        irq_wr.en    = 1'b1;
                        irq_wr.src   = bv[1];
                        irq_wr.gsi   = bv32_2;
                        irq_wr.low   = (bv[6][1:0] == mitp_pkg::FLAG_ASSERTED);
                        irq_wr.level = (bv[6][3:2] == mitp_pkg::FLAG_ASSERTED);
                    end
                end
                mitp_pkg::KIND_LAPIC_ADR:
                begin
                    lapic_next = bv32_2;
                end
                default:
                begin
                end
            endcase
        end
    end

    // walker and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg      <= '0;
            tlen_reg        <= '0;
            pos_reg         <= '0;
            elen_reg        <= '0;
            kind_reg        <= '0;
            boot_id_reg     <= '0;
            boot_found_reg  <= 1'b0;
            lapic_reg       <= mitp_pkg::LAPIC_DEFAULT;
            io_apic_id_reg  <= '0;
            ioapic_base_reg <= '0;
            ioapic_gsi_reg  <= '0;
            error_reg       <= 1'b0;
        end
        else
        begin
            offset_reg      <= offset_next;
            tlen_reg        <= tlen_next;
            pos_reg         <= pos_next;
            elen_reg        <= elen_next;
            kind_reg        <= kind_next;
            boot_id_reg     <= boot_id_next;
            boot_found_reg  <= boot_found_next;
            lapic_reg       <= lapic_next;
            io_apic_id_reg  <= io_apic_id_next;
            ioapic_base_reg <= ioapic_base_next;
            ioapic_gsi_reg  <= ioapic_gsi_next;
            error_reg       <= error_next;
        end
    end

    // entry body bytes
    always_ff @(posedge clk)
    begin
        body_reg <= body_next;
    end

    // status as of the last accepted transfer
    always_comb
    begin
        status.boot_id     = boot_id_reg;
        status.boot_found  = boot_found_reg;
        status.lapic_base  = lapic_reg;
        status.io_apic_id  = io_apic_id_reg;
        status.ioapic_base = ioapic_base_reg;
        status.ioapic_gsi  = ioapic_gsi_reg;
        status.done        = offset_reg >= mitp_pkg::OFS_HDR_MIN && offset_reg >= tlen_reg;
        status.error       = error_reg;
    end

endmodule

// ===== rtl/mitp_irq_table.sv =====
// legacy irq table memory with valid bits and write forwarding
`timescale 1ns / 1ps

module mitp_irq_table #(
    parameter int LEGACY_IRQS = mitp_pkg::LEGACY_IRQS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 rd_en,
    input  logic [3:0]           rd_index,
    input  logic                 clear,
    input  mitp_pkg::irq_wr_t    irq_wr,
    output mitp_pkg::irq_look_t  look
);

    localparam int AW = (LEGACY_IRQS > 1) ? $clog2(LEGACY_IRQS) : 1;

    logic [33:0]            mem [LEGACY_IRQS];
    logic [LEGACY_IRQS-1:0] valid_reg, valid_next;
    logic [33:0]            rd_data_reg;
    logic [33:0]            fwd_data_reg;
    logic                   rd_valid_reg;
    logic                   hit_reg;
    logic                   clr_reg;
    logic                   inr_reg;
    logic [3:0]             idx_reg;
    logic [AW-1:0]          wa;
    logic [AW-1:0]          ra;

    assign wa = AW'(irq_wr.src);
    assign ra = AW'(rd_index);

    // table write
    always_ff @(posedge clk)
    begin
        if (irq_wr.en)
            mem[wa] <= {irq_wr.gsi, irq_wr.low, irq_wr.level};
    end

    // valid bits, an entry not written reads as gsi equal to its index with both flags low
    always_comb
    begin
        valid_next = valid_reg;
        if (clear)
            valid_next = '0;
        else if (irq_wr.en)
            valid_next[wa] = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    // registered read with same-cycle write forwarding
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg  <= mem[ra];
            rd_valid_reg <= valid_reg[ra];
            hit_reg      <= irq_wr.en && (wa == ra);
            fwd_data_reg <= {irq_wr.gsi, irq_wr.low, irq_wr.level};
            clr_reg      <= clear;
            inr_reg      <= 32'(rd_index) < LEGACY_IRQS;
            idx_reg      <= rd_index;
        end
    end

    // lookup result
    always_comb
    begin
        if (!inr_reg || clr_reg)
            look = {32'(idx_reg), 1'b0, 1'b0};
        else if (hit_reg)
            look = fwd_data_reg;
        else if (rd_valid_reg)
            look = rd_data_reg;
        else
            look = {32'(idx_reg), 1'b0, 1'b0};
    end

endmodule

// ===== rtl/madt_interrupt_table_parser_core.sv =====
// madt interrupt table parser: stream ports, lookup stage and output register
// an accepted input transfer is registered in the lookup stage and then in the output register,
// which drives m_tvalid; the lookup stage waits while the output register is held by m_tready low
// throughput: one transfer per cycle while m_tready is high; the irq table memory serves one
// write and one read each cycle and the parser takes one table byte per accepted transfer
// reset: rst_n clears the parser state, result registers and irq valid bits at once;
// func clear restores the same values in one transfer
`timescale 1ns / 1ps

module madt_interrupt_table_parser_core #(
    parameter int LEGACY_IRQS      = mitp_pkg::LEGACY_IRQS_DEF,
    parameter int ENTRY_BYTES_KEPT = mitp_pkg::ENTRY_BYTES_KEPT_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // data_byte [7:0], irq_index [11:8], zero [15:12]
    input  logic [mitp_pkg::S_TDATA_W-1:0] s_tdata,
    // func [1:0], table_start [2]
    input  logic [mitp_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // boot_cpu_apic_id [7:0], boot_cpu_found [8], local_apic_base [40:9],
    // io_apic_id [48:41], io_apic_base [80:49], io_apic_gsi_start [112:81],
    // irq_gsi [144:113], irq_low_active [145], irq_level_mode [146],
    // table_done [147], format_error [148], zero [151:149]
    output logic [mitp_pkg::M_TDATA_W-1:0] m_tdata
);

    logic                          accept;
    logic                          o_load;
    logic                          p1_valid_reg, p1_valid_next;
    logic                          o_valid_reg, o_valid_next;
    logic [mitp_pkg::M_DATA_W-1:0] o_data_reg;
    mitp_pkg::func_t               func;
    mitp_pkg::status_t             status;
    mitp_pkg::irq_wr_t             irq_wr;
    mitp_pkg::irq_look_t           look;

    assign func = mitp_pkg::func_t'(s_tuser[1:0]);

    // handshake: lookup stage then output register
    assign o_load   = p1_valid_reg && (!o_valid_reg || m_tready);
    assign s_tready = !p1_valid_reg || o_load;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        p1_valid_next = p1_valid_reg;
        if (accept)
            p1_valid_next = 1'b1;
        else if (o_load)
            p1_valid_next = 1'b0;

        o_valid_next = o_valid_reg;
        if (o_load)
            o_valid_next = 1'b1;
        else if (m_tready)
            o_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
            o_valid_reg  <= 1'b0;
        end
        else
        begin
            p1_valid_reg <= p1_valid_next;
            o_valid_reg  <= o_valid_next;
        end
    end

    mitp_parser #(
        .LEGACY_IRQS      (LEGACY_IRQS),
        .ENTRY_BYTES_KEPT (ENTRY_BYTES_KEPT)
    ) u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (accept),
        .func        (func),
        .table_start (s_tuser[2]),
        .data_byte   (s_tdata[7:0]),
        .status      (status),
        .irq_wr      (irq_wr)
    );

    mitp_irq_table #(
        .LEGACY_IRQS (LEGACY_IRQS)
    ) u_irq_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (accept),
        .rd_index (s_tdata[11:8]),
        .clear    (accept && func == mitp_pkg::FUNC_CLEAR),
        .irq_wr   (irq_wr),
        .look     (look)
    );

    // output register, parser status is the state after the staged transfer
    always_ff @(posedge clk)
    begin
        if (o_load)
            o_data_reg <= {status.error, status.done, look.level, look.low, look.gsi,
                           status.ioapic_gsi, status.ioapic_base, status.io_apic_id,
                           status.lapic_base, status.boot_found, status.boot_id};
    end

    assign m_tvalid = o_valid_reg;
    assign m_tdata  = {{(mitp_pkg::M_TDATA_W - mitp_pkg::M_DATA_W){1'b0}}, o_data_reg};

endmodule
